// ----- sv/postfix_stack_evaluator_macros.svh -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_macros.svh
// Assertion macros shared by the postfix stack evaluator RTL.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define PSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define PSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/pse_pkg.sv -----
// ----------------------------------------------------------------------------
// pse_pkg
// Widths, token and status codes and the divider handshake types of the
// postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

   localparam int DATA_W   = 32;
   localparam int MODE_W   = 3;
   localparam int DEPTH_W  = 5;
   localparam int STATUS_W = 2;
   localparam int STEP_W   = $clog2(DATA_W);

   // token kinds
   localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDER = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIV0  = 2'd3;

   // last step of the bit-serial divider
   localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(DATA_W - 1);

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } pse_div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DATA_W-1:0] quotient;
   } pse_div_rsp_type;

endpackage

`default_nettype wire

// ----- sv/pse_divider.sv -----
// ----------------------------------------------------------------------------
// pse_divider
// Signed 32-bit divider, truncating toward zero. Restoring, one quotient bit
// per cycle on magnitudes, then a final step applies the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_divider (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pse_pkg::pse_div_req_type div_req,
   output pse_pkg::pse_div_rsp_type      div_rsp
);
   import pse_pkg::*;

   logic              busy_ff, busy_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] mag_d_ff, mag_d_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] result_ff, result_in;

   logic [DATA_W-1:0] shifted;
   logic [DATA_W:0]   trial;

   // one restoring step: shift in the next dividend bit, try the subtraction
   assign shifted = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
   assign trial   = {1'b0, shifted} - {1'b0, mag_d_ff};

   always_comb begin
      busy_in   = busy_ff;
      fix_in    = 1'b0;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      mag_d_in  = mag_d_ff;
      neg_in    = neg_ff;
      result_in = result_ff;

      priority if (div_req.start) begin
         // load magnitudes and the sign of the quotient
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = '0;
         quo_in   = div_req.dividend[DATA_W-1] ? (DATA_W'(0) - div_req.dividend)
                                                : div_req.dividend;
         mag_d_in = div_req.divisor[DATA_W-1] ? (DATA_W'(0) - div_req.divisor)
                                              : div_req.divisor;
         neg_in   = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
      end else if (busy_ff) begin
         // advance one quotient bit
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == DIV_LAST_STEP) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         // apply the sign
         result_in = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
         done_in   = 1'b1;
      end else begin
         // idle: hold the datapath registers
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      mag_d_ff  <= mag_d_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign div_rsp.busy     = busy_ff | fix_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = result_ff;

endmodule

`default_nettype wire

// ----- sv/postfix_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Reverse Polish evaluator on a bounded stack of signed 32-bit integers.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_mode, req_operand_value
//   rsp      out        rsp_valid/rsp_stall   rsp_top_value, rsp_stack_depth,
//                                             rsp_status
//
// Push, add, subtract, multiply, unused and flagged tokens pass from transfer
// through the execute and commit states; a divide that reaches the divider
// also waits in ST_DIVW for the one-bit-per-cycle divider.
// The top of stack lives in a register; the entries below it sit in a
// synchronous RAM read once per operator. Reset clears the depth; the RAM is
// not cleared. A new token is taken while the last result waits on
// rsp_stall; the following result is then held until the output is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "postfix_stack_evaluator_macros.svh"

module postfix_stack_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [pse_pkg::MODE_W-1:0]       req_mode,
   input  wire logic signed [pse_pkg::DATA_W-1:0] req_operand_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [pse_pkg::DATA_W-1:0]     rsp_top_value,
   output logic [pse_pkg::DEPTH_W-1:0]           rsp_stack_depth,
   output logic [pse_pkg::STATUS_W-1:0]          rsp_status
);
   import pse_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PW = $clog2(STACK_DEPTH + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_DIVW   = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [DATA_W-1:0]   top_ff, top_in;
   logic [PW-1:0]       sp_ff, sp_in;
   logic [DATA_W-1:0]   res_top_ff, res_top_in;
   logic [PW-1:0]       res_sp_ff, res_sp_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_push_ff, res_push_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0]   rd_data_ff;
   logic [AW-1:0]       rd_idx;
   logic [AW-1:0]       wr_idx;
   logic                wr_en;

   logic                req_xfer;
   logic                out_free;
   logic                two_held;
   logic                full;

   pse_div_req_type     div_req;
   pse_div_rsp_type     div_rsp;

   assign req_xfer = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign two_held = sp_ff >= PW'(2);
   assign full     = sp_ff >= PW'(STACK_DEPTH);

   // next-over-top sits just below the top register
   assign rd_idx = AW'(sp_ff - PW'(2));
   // on a push the old top drops into the RAM
   assign wr_idx = AW'(sp_ff - PW'(1));
   assign wr_en  = (state_ff == ST_COMMIT) && out_free && res_push_ff && (sp_ff != '0);

   // stack RAM: one registered read port, one write port
   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem[rd_idx];
      if (wr_en) begin
         stack_mem[wr_idx] <= top_ff;
      end
   end

   pse_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      div_req.start    = (state_ff == ST_EXEC) && (mode_ff == MODE_DIV) && two_held
                         && (top_ff != '0);
      div_req.dividend = rd_data_ff;
      div_req.divisor  = top_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      top_in        = top_ff;
      sp_in         = sp_ff;
      res_top_in    = res_top_ff;
      res_sp_in     = res_sp_ff;
      res_status_in = res_status_ff;
      res_push_in   = res_push_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // capture the token; the RAM read of next-over-top starts now
            if (req_xfer) begin
               mode_in  = req_mode;
               value_in = req_operand_value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // default: stack unchanged
            res_top_in    = top_ff;
            res_sp_in     = sp_ff;
            res_status_in = STATUS_OK;
            res_push_in   = 1'b0;
            state_in      = ST_COMMIT;
            unique case (mode_ff)
               MODE_PUSH: begin
                  if (full) begin
                     res_status_in = STATUS_OVER;
                  end else begin
                     res_top_in  = value_ff;
                     res_sp_in   = sp_ff + PW'(1);
                     res_push_in = 1'b1;
                  end
               end
               MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                  priority if (!two_held) begin
                     res_status_in = STATUS_UNDER;
                  end else if (mode_ff == MODE_ADD) begin
                     res_top_in = rd_data_ff + top_ff;
                     res_sp_in  = sp_ff - PW'(1);
                  end else if (mode_ff == MODE_SUB) begin
                     res_top_in = rd_data_ff - top_ff;
                     res_sp_in  = sp_ff - PW'(1);
                  end else if (mode_ff == MODE_MUL) begin
                     res_top_in = DATA_W'(rd_data_ff * top_ff);
                     res_sp_in  = sp_ff - PW'(1);
                  end else if (top_ff == '0) begin
                     res_status_in = STATUS_DIV0;
                  end else begin
                     res_sp_in = sp_ff - PW'(1);
                     state_in  = ST_DIVW;
                  end
               end
               default: begin
                  // unused token: no operation
               end
            endcase
         end
         ST_DIVW: begin
            // hold until the quotient is ready
            if (div_rsp.done) begin
               res_top_in = div_rsp.quotient;
               state_in   = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // update the stack and present the result once the output is free
            if (out_free) begin
               top_in        = res_top_ff;
               sp_in         = res_sp_ff;
               rsp_valid_in  = 1'b1;
               rsp_top_in    = (res_sp_ff != '0) ? res_top_ff : '0;
               rsp_depth_in  = DEPTH_W'(res_sp_ff);
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      top_ff        <= top_in;
      res_top_ff    <= res_top_in;
      res_sp_ff     <= res_sp_in;
      res_status_ff <= res_status_in;
      res_push_ff   <= res_push_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_stack_depth = rsp_depth_ff;
   assign rsp_status      = rsp_status_ff;

   // checks
   `PSE_ASSERT_NOW(a_depth_bound, clock, reset, 1'b1, sp_ff <= PW'(STACK_DEPTH), "stack depth beyond capacity")
   `PSE_ASSERT_NOW(a_sp_moves_on_commit, clock, reset, sp_ff != $past(sp_ff), $past(state_ff) == ST_COMMIT, "depth changed outside commit")
   `PSE_ASSERT_NOW(a_div_done_in_wait, clock, reset, div_rsp.done, state_ff == ST_DIVW, "quotient arrived with no division waiting")
   `PSE_ASSERT_NOW(a_div_busy_in_wait, clock, reset, div_rsp.busy, state_ff == ST_DIVW, "divider running outside wait")
   `PSE_ASSERT_NEXT(a_commit_shows_result, clock, reset, (state_ff == ST_COMMIT) && out_free, rsp_valid_ff && (state_ff == ST_IDLE), "commit did not present a result")

endmodule

`default_nettype wire
